// ----- sv/adsr_pkg.sv -----
// Shared widths, types and helper functions for the ADSR envelope level pipeline.
package adsr_pkg;

  // Field widths
  localparam int TIME_W     = 32;
  localparam int SUM_W      = TIME_W + 1;
  localparam int LVL_FRAC   = 16;
  localparam int LVL_W      = LVL_FRAC + 1;
  localparam int CURVE_W    = 16;
  localparam int CURVE_FRAC = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TIME_W;

  localparam logic [LVL_W-1:0] LVL_ONE = {1'b1, {LVL_FRAC{1'b0}}};

  // Log2 / exp2 arithmetic
  localparam int LG_FRAC   = 16;
  localparam int LG_INT_W  = 5;
  localparam int LG_W      = LG_INT_W + LG_FRAC;
  localparam int MANT_FRAC = 30;
  localparam int MANT_W    = MANT_FRAC + 1;
  localparam int P_W       = LG_W + CURVE_FRAC;
  localparam int N_W       = 6;
  localparam int N_LIMIT   = 40;

  localparam logic [MANT_W-1:0] MANT_ONE = {1'b1, {MANT_FRAC{1'b0}}};

  // Pipeline depths
  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = (P_W + DIV_STEP - 1) / DIV_STEP;
  localparam int LG_LAT     = LG_FRAC + 1;
  localparam int EXP_STAGES = LG_FRAC;
  localparam int POW_LAT    = LG_LAT + 1 + DIV_STAGES + 1 + EXP_STAGES + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_CURVE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_CURVE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_CURVE = 3'd6;

  // Request into a power unit: (num/den)^curve, or ^(1/curve) when recip
  typedef struct packed {
    logic [TIME_W-1:0]  num;
    logic [TIME_W-1:0]  den;
    logic [CURVE_W-1:0] curve;
    logic               recip;
  } pow_req_t;

  // Q1.30 product, truncated, one extra bit on top
  function automatic logic [MANT_W:0] mant_mul(input logic [MANT_W-1:0] a,
                                              input logic [MANT_W-1:0] b);
    logic [2*MANT_W-1:0] prod;
    prod = a * b;
    return prod[MANT_FRAC +: MANT_W+1];
  endfunction

  // Integer square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_w;
    rem = v;
    res = '0;
    for (int j = 0; j < 32; j++) begin
      bit_w = 64'd1 << (62 - 2*j);
      if (rem >= res + bit_w) begin
        rem = rem - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // 2^-(2^-i) in Q1.30 for i = 1..LG_FRAC, packed low entry first
  function automatic logic [LG_FRAC*MANT_W-1:0] exp_taps();
    logic [63:0] t;
    logic [LG_FRAC*MANT_W-1:0] taps;
    t    = isqrt64(64'd1 << (2*MANT_FRAC - 1));
    taps = '0;
    for (int i = 0; i < LG_FRAC; i++) begin
      taps[i*MANT_W +: MANT_W] = t[MANT_W-1:0];
      t = isqrt64(t << MANT_FRAC);
    end
    return taps;
  endfunction

endpackage

// ----- sv/adsr_envelope_level.sv -----
// ADSR envelope level pipeline top level: configuration, phase decode, level combine.
// One word in and one level out per clock cycle while each output word is taken. The
// pipeline is the two phase-decode stages, the power units (17-stage log2 squaring
// chain, 11-stage divider for the attack exponent, 16-stage exp2 multiply chain,
// select and shift stages), and two combine stages. The whole pipeline holds while the
// output word waits to be taken, so nothing is lost or repeated.
module adsr_envelope_level
  import adsr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TIME_W-1:0]     elapsed_i,
  input  logic                  key_held_i,
  input  logic [TIME_W-1:0]     release_at_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [LVL_W-1:0]      level_o,
  output logic                  finished_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int NST = POW_LAT + 4;

  typedef struct packed {
    logic             att;
    logic             dec;
    logic             rel;
    logic             fin;
    logic [LVL_W-1:0] sus;
  } side_t;

  // Configuration registers
  logic [TIME_W-1:0]  attack_len_q, decay_len_q, release_len_q;
  logic [LVL_W-1:0]   sustain_q;
  logic [CURVE_W-1:0] attack_curve_q, decay_curve_q, release_curve_q;

  logic [NST-1:0]     vld_q;
  logic               en;

  // Stage 1
  logic [TIME_W-1:0]  t1_q, r1_q;
  logic               held1_q, fin1_q, late1_q;
  logic [SUM_W-1:0]   apd1_q, rend1_q, apd_d, rend_d;

  // Stage 2
  logic [TIME_W-1:0]  x;
  logic               att, dec;
  logic [LVL_W-1:0]   s_sat;
  pow_req_t           reqa_d, reqb_d, reqa_q, reqb_q;
  side_t              side_d, side2_q;
  side_t              ts_q [POW_LAT];

  // Combine stages
  logic [LVL_W-1:0]   pa, pb;
  side_t              sd;
  logic [2*LVL_W-1:0] dprod, rprod;
  logic [LVL_W:0]     dsum;
  logic [LVL_W-1:0]   lvl1_d, lvl1_q, pb1_q, rlvl, out_d;
  logic               rel1_q, fin1c_q;
  logic [LVL_W-1:0]   level_q;
  logic               fin_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_len_q    <= '0;
      decay_len_q     <= '0;
      sustain_q       <= LVL_ONE;
      release_len_q   <= '0;
      attack_curve_q  <= CURVE_W'(4096);
      decay_curve_q   <= CURVE_W'(4096);
      release_curve_q <= CURVE_W'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ATTACK_LEN:    attack_len_q    <= cfg_wdata_i[TIME_W-1:0];
        REG_DECAY_LEN:     decay_len_q     <= cfg_wdata_i[TIME_W-1:0];
        REG_SUSTAIN_LEVEL: sustain_q       <= cfg_wdata_i[LVL_W-1:0];
        REG_RELEASE_LEN:   release_len_q   <= cfg_wdata_i[TIME_W-1:0];
        REG_ATTACK_CURVE:  attack_curve_q  <= cfg_wdata_i[CURVE_W-1:0];
        REG_DECAY_CURVE:   decay_curve_q   <= cfg_wdata_i[CURVE_W-1:0];
        REG_RELEASE_CURVE: release_curve_q <= cfg_wdata_i[CURVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless the output word is stuck
  assign en         = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // Stage 1: phase boundaries
  assign apd_d  = {1'b0, attack_len_q} + {1'b0, decay_len_q};
  assign rend_d = {1'b0, release_at_i} + {1'b0, release_len_q};

  // Stage 2: pick the level-curve time and build both power requests
  always_comb begin
    x     = (!held1_q && late1_q) ? r1_q : t1_q;
    att   = x < attack_len_q;
    dec   = !att && ({1'b0, x} < apd1_q);
    s_sat = (sustain_q > LVL_ONE) ? LVL_ONE : sustain_q;

    if (att) begin
      reqa_d = '{num: x, den: attack_len_q, curve: attack_curve_q, recip: 1'b1};
    end else begin
      reqa_d = '{num: TIME_W'(apd1_q - {1'b0, x}), den: decay_len_q,
                 curve: decay_curve_q, recip: 1'b0};
    end
    reqb_d = '{num: TIME_W'(rend1_q - {1'b0, t1_q}), den: release_len_q,
               curve: release_curve_q, recip: 1'b0};

    side_d.att = att;
    side_d.dec = dec;
    side_d.rel = !held1_q && late1_q && !fin1_q;
    side_d.fin = fin1_q;
    side_d.sus = s_sat;
  end

  // Level curve and release curve
  adsr_pow u_pow_lvl (.clk_i, .en_i(en), .req_i(reqa_q), .p_o(pa));
  adsr_pow u_pow_rel (.clk_i, .en_i(en), .req_i(reqb_q), .p_o(pb));

  // Combine 1: attack, decay or sustain level
  always_comb begin
    sd     = ts_q[POW_LAT-1];
    dprod  = pa * (LVL_ONE - sd.sus);
    dsum   = dprod[LVL_FRAC +: LVL_W+1] + {1'b0, sd.sus};
    lvl1_d = sd.att ? pa : (sd.dec ? dsum[LVL_W-1:0] : sd.sus);
  end

  // Combine 2: release scaling, finished forces zero
  always_comb begin
    rprod = pb1_q * lvl1_q;
    rlvl  = (rprod[LVL_FRAC +: LVL_W+1] > {1'b0, LVL_ONE}) ? LVL_ONE
                                                           : rprod[LVL_FRAC +: LVL_W];
    if (fin1c_q) begin
      out_d = '0;
    end else if (rel1_q) begin
      out_d = rlvl;
    end else begin
      out_d = (lvl1_q > LVL_ONE) ? LVL_ONE : lvl1_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q    <= elapsed_i;
      r1_q    <= release_at_i;
      held1_q <= key_held_i;
      apd1_q  <= apd_d;
      rend1_q <= rend_d;
      fin1_q  <= !key_held_i && ({1'b0, elapsed_i} > rend_d);
      late1_q <= elapsed_i > release_at_i;

      reqa_q  <= reqa_d;
      reqb_q  <= reqb_d;
      side2_q <= side_d;

      ts_q[0] <= side2_q;
      for (int i = 1; i < POW_LAT; i++) ts_q[i] <= ts_q[i-1];

      lvl1_q  <= lvl1_d;
      pb1_q   <= pb;
      rel1_q  <= sd.rel;
      fin1c_q <= sd.fin;

      level_q <= out_d;
      fin_q   <= fin1c_q;
    end
  end

  assign out_valid_o = vld_q[NST-1];
  assign level_o     = level_q;
  assign finished_o  = fin_q;

  // Checks
  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> level_o == '0)
    else $error("finished word carries a nonzero level");

  a_lvl_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_o <= LVL_ONE)
    else $error("level above full scale");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted word not captured in first stage");

endmodule

// ----- sv/adsr_lg.sv -----
// Pipelined fixed-point log2: normalize, then one truncated squaring per stage.
module adsr_lg
  import adsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [TIME_W-1:0] v_i,
  output logic [LG_W-1:0]   lg_o
);

  logic [MANT_W-1:0]   m_q  [LG_LAT];
  logic [LG_FRAC-1:0]  fr_q [LG_LAT];
  logic [LG_INT_W-1:0] k_q  [LG_LAT];
  logic [LG_INT_W-1:0] k_d;
  logic [MANT_W-1:0]   m_d;
  logic [LG_FRAC-1:0][MANT_W:0] sq_w;

  // Leading one and normalize to Q1.30
  always_comb begin
    k_d = '0;
    for (int b = 0; b < TIME_W; b++) begin
      if (v_i[b]) k_d = LG_INT_W'(b);
    end
    if (k_d == LG_INT_W'(TIME_W-1)) begin
      m_d = v_i[TIME_W-1 -: MANT_W];
    end else begin
      m_d = MANT_W'(v_i << (LG_INT_W'(MANT_FRAC) - k_d));
    end
  end

  // Squaring per stage
  for (genvar g = 0; g < LG_FRAC; g++) begin : g_sq
    assign sq_w[g] = mant_mul(m_q[g], m_q[g]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]  <= m_d;
      fr_q[0] <= '0;
      k_q[0]  <= k_d;
      for (int s = 0; s < LG_FRAC; s++) begin
        // square >= 2 yields a one bit and halves
        m_q[s+1]  <= sq_w[s][MANT_W] ? sq_w[s][MANT_W:1] : sq_w[s][MANT_W-1:0];
        fr_q[s+1] <= {fr_q[s][LG_FRAC-2:0], sq_w[s][MANT_W]};
        k_q[s+1]  <= k_q[s];
      end
    end
  end

  assign lg_o = {k_q[LG_LAT-1], fr_q[LG_LAT-1]};

endmodule

// ----- sv/adsr_div.sv -----
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
module adsr_div
  import adsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [P_W-1:0]     dividend_i,
  input  logic [CURVE_W-1:0] divisor_i,
  output logic [P_W-1:0]     quot_o
);

  logic [CURVE_W:0]   rem_q  [DIV_STAGES+1];
  logic [P_W-1:0]     work_q [DIV_STAGES+1];
  logic [CURVE_W-1:0] dv_q   [DIV_STAGES+1];

  // work holds remaining dividend bits on top, quotient bits shift in below
  function automatic logic [CURVE_W+P_W:0] div_step(input logic [CURVE_W:0]   rem,
                                                   input logic [P_W-1:0]     work,
                                                   input logic [CURVE_W-1:0] dv);
    logic [CURVE_W:0] r;
    logic [P_W-1:0]   w;
    r = rem;
    w = work;
    for (int j = 0; j < DIV_STEP; j++) begin
      r = {r[CURVE_W-1:0], w[P_W-1]};
      w = {w[P_W-2:0], 1'b0};
      if (r >= {1'b0, dv}) begin
        r    = r - {1'b0, dv};
        w[0] = 1'b1;
      end
    end
    return {r, w};
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      work_q[0] <= dividend_i;
      dv_q[0]   <= divisor_i;
      for (int g = 0; g < DIV_STAGES; g++) begin
        {rem_q[g+1], work_q[g+1]} <= div_step(rem_q[g], work_q[g], dv_q[g]);
        dv_q[g+1] <= dv_q[g];
      end
    end
  end

  assign quot_o = work_q[DIV_STAGES];

endmodule

// ----- sv/adsr_pow.sv -----
// Pipelined power unit: (num/den)^e as exp2(e * log2(num/den)), Q1.16 result.
module adsr_pow
  import adsr_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  pow_req_t         req_i,
  output logic [LVL_W-1:0] p_o
);

  localparam logic [LG_FRAC*MANT_W-1:0] TAPS = exp_taps();

  typedef struct packed {
    logic               zero;
    logic               recip;
    logic [CURVE_W-1:0] curve;
  } pside_t;

  typedef struct packed {
    logic           zero;
    logic           recip;
    logic [P_W-1:0] pm;
  } dside_t;

  pside_t              sd_q [LG_LAT];
  pside_t              sd_d;
  pside_t              ls_q;
  dside_t              dp_q [DIV_STAGES];
  dside_t              dl;
  logic [LG_W-1:0]     lgn, lgd, l_d, l_q;
  logic [P_W-1:0]      quot, psel;
  logic                pz;
  logic [LG_W+CURVE_W-1:0] lc;
  logic [MANT_W-1:0]   em_q [EXP_STAGES+1];
  logic [LG_FRAC-1:0]  ef_q [EXP_STAGES+1];
  logic [N_W-1:0]      ne_q [EXP_STAGES+1];
  logic                ez_q [EXP_STAGES+1];
  logic [EXP_STAGES-1:0][MANT_W:0] ex_w;
  logic [N_W-1:0]      sh_amt;
  logic [LVL_W-1:0]    p_d, p_q;

  // Log2 of numerator and denominator
  adsr_lg u_lg_num (.clk_i, .en_i, .v_i(req_i.num), .lg_o(lgn));
  adsr_lg u_lg_den (.clk_i, .en_i, .v_i(req_i.den), .lg_o(lgd));

  always_comb begin
    sd_d.zero  = (req_i.num == '0) || (req_i.den == '0);
    sd_d.recip = req_i.recip;
    sd_d.curve = (req_i.curve == '0) ? CURVE_W'(1) : req_i.curve;
  end

  // Negated log of the ratio, clamped at zero
  assign l_d = (lgd > lgn) ? (lgd - lgn) : '0;

  // Reciprocal exponent: (L << 12) / c
  adsr_div u_div (
    .clk_i,
    .en_i,
    .dividend_i({l_d, {CURVE_FRAC{1'b0}}}),
    .divisor_i (sd_q[LG_LAT-1].curve),
    .quot_o    (quot)
  );

  // Direct exponent: (L * c) >> 12
  assign lc = l_q * ls_q.curve;

  // Exponent select, then split into integer shift and fraction bits
  always_comb begin
    dl   = dp_q[DIV_STAGES-1];
    psel = dl.recip ? quot : dl.pm;
    pz   = dl.zero || (psel[P_W-1:LG_FRAC] >= (P_W-LG_FRAC)'(N_LIMIT));
  end

  for (genvar e = 0; e < EXP_STAGES; e++) begin : g_exp
    assign ex_w[e] = mant_mul(em_q[e], TAPS[e*MANT_W +: MANT_W]);
  end

  // Final shift into Q1.16
  always_comb begin
    sh_amt = N_W'(MANT_FRAC - LVL_FRAC) + ne_q[EXP_STAGES];
    p_d    = ez_q[EXP_STAGES] ? '0 : LVL_W'(em_q[EXP_STAGES] >> sh_amt);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0] <= sd_d;
      for (int i = 1; i < LG_LAT; i++) sd_q[i] <= sd_q[i-1];

      l_q  <= l_d;
      ls_q <= sd_q[LG_LAT-1];

      dp_q[0] <= '{zero: ls_q.zero, recip: ls_q.recip, pm: P_W'(lc >> CURVE_FRAC)};
      for (int i = 1; i < DIV_STAGES; i++) dp_q[i] <= dp_q[i-1];

      em_q[0] <= MANT_ONE;
      ef_q[0] <= psel[LG_FRAC-1:0];
      ne_q[0] <= psel[LG_FRAC +: N_W];
      ez_q[0] <= pz;
      // one fraction bit per stage, most significant first
      for (int e = 0; e < EXP_STAGES; e++) begin
        em_q[e+1] <= ef_q[e][LG_FRAC-1-e] ? ex_w[e][MANT_W-1:0] : em_q[e];
        ef_q[e+1] <= ef_q[e];
        ne_q[e+1] <= ne_q[e];
        ez_q[e+1] <= ez_q[e];
      end

      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- dv/adsr_envelope_level_tb.sv -----
// Self-checking testbench for the ADSR envelope level pipeline.
module adsr_envelope_level_tb;
  import adsr_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int WORDS_PER_PHASE = 90;
  localparam int NUM_PHASES = 9;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [TIME_W-1:0]     elapsed_i = '0;
  logic                  key_held_i = 1'b0;
  logic [TIME_W-1:0]     release_at_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [LVL_W-1:0]      level_o;
  logic                  finished_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  adsr_envelope_level uut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor copy of the registers
  logic [63:0] atk_len, dec_len, sus_lvl, rel_len, atk_crv, dec_crv, rel_crv;

  typedef struct {
    logic [LVL_W-1:0] level;
    logic             fin;
  } env_out_t;

  env_out_t    level_q[$];
  int          mismatches = 0;
  int          words_in = 0;
  int          words_out = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // log2 with 16 fraction bits by repeated squaring
  function automatic logic [63:0] log2_q16(input logic [63:0] v);
    int k;
    logic [63:0] m, frac;
    k = 63;
    frac = 0;
    while (k > 0 && v[k] == 1'b0) k--;
    m = (k > 30) ? (v >> (k - 30)) : (v << (30 - k));
    for (int i = 0; i < LG_FRAC; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    return (64'(k) << LG_FRAC) | frac;
  endfunction

  // (num/den)^c, or ^(1/c) for the attack, at 16 fraction bits
  function automatic logic [63:0] ratio_pow(input logic [63:0] num, input logic [63:0] den,
                                           input logic [63:0] c, input bit recip);
    longint ld;
    logic [63:0] lsp, p, n, f, m, t;
    if (num == 0 || den == 0) return 0;
    if (c == 0) c = 1;
    ld = longint'(log2_q16(den)) - longint'(log2_q16(num));
    lsp = (ld > 0) ? 64'(ld) : 64'd0;
    p = recip ? ((lsp << CURVE_FRAC) / c) : ((lsp * c) >> CURVE_FRAC);
    n = p >> LG_FRAC;
    if (n >= 40) return 0;
    f = p & 64'hFFFF;
    m = 64'd1 << 30;
    t = int_sqrt(64'd1 << 59);
    for (int i = 1; i <= LG_FRAC; i++) begin
      if (f[LG_FRAC-i]) m = (m * t) >> 30;
      t = int_sqrt(t << 30);
    end
    return m >> (14 + n);
  endfunction

  function automatic logic [63:0] held_level(input logic [63:0] t, input logic [63:0] s);
    logic [63:0] p;
    if (t < atk_len) return ratio_pow(t, atk_len, atk_crv, 1'b1);
    if (t < atk_len + dec_len) begin
      p = ratio_pow(atk_len + dec_len - t, dec_len, dec_crv, 1'b0);
      return ((p * (64'd65536 - s)) >> 16) + s;
    end
    return s;
  endfunction

  function automatic env_out_t predict_level(input logic [31:0] e, input logic k,
                                             input logic [31:0] r);
    env_out_t o;
    logic [63:0] t, rr, s, amp, p, lvl;
    t = e;
    rr = r;
    s = (sus_lvl > 64'd65536) ? 64'd65536 : sus_lvl;
    o.fin = 1'b0;
    if (!k && t > rr + rel_len) begin
      lvl = 0;
      o.fin = 1'b1;
    end else if (!k && t > rr) begin
      amp = held_level(rr, s);
      p = ratio_pow(rr + rel_len - t, rel_len, rel_crv, 1'b0);
      lvl = (p * amp) >> 16;
    end else begin
      lvl = held_level(t, s);
    end
    if (lvl > 64'd65536) lvl = 64'd65536;
    o.level = lvl[LVL_W-1:0];
    return o;
  endfunction

  // Reset-value registers for the predictor
  initial begin
    atk_len = 0; dec_len = 0; sus_lvl = 65536; rel_len = 0;
    atk_crv = 4096; dec_crv = 4096; rel_crv = 4096;
  end

  // Timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, level_q.size());
      $display("adsr_envelope_level_tb: done, errors");
      $finish;
    end
  end

  // Receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Output check against the oldest expected level
  always @(posedge clk_i) begin
    env_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_out++;
      if (level_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: level %0d finished %0b", level_o, finished_o);
      end else begin
        want = level_q.pop_front();
        if (want.level !== level_o || want.fin !== finished_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch word %0d: level exp %0d got %0d, finished exp %0b got %0b",
                     words_out, want.level, level_o, want.fin, finished_o);
        end
      end
    end
  end

  // Drive one word; entered and left at a falling edge
  task automatic send_word(input logic [31:0] e, input logic k, input logic [31:0] r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    elapsed_i <= e;
    key_held_i <= k;
    release_at_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    level_q.push_back(predict_level(e, k, r));
    words_in++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (level_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v[31:0];
    case (idx)
      REG_ATTACK_LEN:    atk_len = v & 64'hFFFFFFFF;
      REG_DECAY_LEN:     dec_len = v & 64'hFFFFFFFF;
      REG_SUSTAIN_LEVEL: sus_lvl = v & 64'h1FFFF;
      REG_RELEASE_LEN:   rel_len = v & 64'hFFFFFFFF;
      REG_ATTACK_CURVE:  atk_crv = v & 64'hFFFF;
      REG_DECAY_CURVE:   dec_crv = v & 64'hFFFF;
      default:           rel_crv = v & 64'hFFFF;
    endcase
    @(negedge clk_i);
  endtask

  typedef struct {
    logic [63:0] a, d, s, rl, ac, dc, rc;
  } env_cfg_t;

  task automatic load_cfg(input env_cfg_t c);
    write_reg(REG_ATTACK_LEN, c.a);
    write_reg(REG_DECAY_LEN, c.d);
    write_reg(REG_SUSTAIN_LEVEL, c.s);
    write_reg(REG_RELEASE_LEN, c.rl);
    write_reg(REG_ATTACK_CURVE, c.ac);
    write_reg(REG_DECAY_CURVE, c.dc);
    write_reg(REG_RELEASE_CURVE, c.rc);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random word aimed at the phase boundaries of the current setting
  task automatic send_random();
    logic [63:0] span, e, r;
    logic k;
    k = $urandom_range(0, 2) == 0;
    if ($urandom_range(0, 7) == 0) begin
      e = $urandom;
      r = $urandom;
    end else begin
      span = atk_len + dec_len + rel_len + 16;
      if (span > 64'hFFFFFFFF) span = 64'hFFFFFFFF;
      e = 64'($urandom) % (span + 1);
      if ($urandom_range(0, 3) == 0) r = 64'($urandom) % (span + 1);
      else r = 64'($urandom) % (e + 1);
    end
    send_word(e[31:0], k, r[31:0]);
  endtask

  typedef struct {
    logic [31:0]      e;
    logic             k;
    logic [31:0]      r;
    bit               typed;
    logic [LVL_W-1:0] lvl;
    logic             fin;
  } stim_row_t;

  // Reset setting: all lengths zero, full sustain
  stim_row_t reset_rows[] = '{
    '{32'h0,        1'b1, 32'h0,        1'b1, 17'd65536, 1'b0},
    '{32'hFFFFFFFF, 1'b1, 32'h0,        1'b1, 17'd65536, 1'b0},
    '{32'h0,        1'b0, 32'h0,        1'b1, 17'd65536, 1'b0},
    '{32'h1,        1'b0, 32'h0,        1'b1, 17'd0,     1'b1},
    '{32'hFFFFFFFF, 1'b0, 32'hFFFFFFFF, 1'b1, 17'd65536, 1'b0},
    '{32'hFFFFFFFF, 1'b0, 32'hFFFFFFFE, 1'b1, 17'd0,     1'b1},
    '{32'h0,        1'b0, 32'hFFFFFFFF, 1'b1, 17'd65536, 1'b0},
    '{32'hFFFFFFFF, 1'b0, 32'h0,        1'b1, 17'd0,     1'b1},
    '{32'hAAAAAAAA, 1'b1, 32'h55555555, 1'b1, 17'd65536, 1'b0},
    '{32'h55555555, 1'b0, 32'hAAAAAAAA, 1'b1, 17'd65536, 1'b0}
  };

  // A=16 D=16 S=0.5 R=16: each phase and release point
  stim_row_t phase_rows[] = '{
    '{32'd0,  1'b1, 32'd0,  1'b0, 17'd0, 1'b0},
    '{32'd8,  1'b1, 32'd0,  1'b0, 17'd0, 1'b0},
    '{32'd15, 1'b1, 32'd0,  1'b0, 17'd0, 1'b0},
    '{32'd24, 1'b1, 32'd0,  1'b0, 17'd0, 1'b0},
    '{32'd40, 1'b1, 32'd0,  1'b0, 17'd0, 1'b0},
    '{32'd10, 1'b0, 32'd5,  1'b0, 17'd0, 1'b0},
    '{32'd22, 1'b0, 32'd20, 1'b0, 17'd0, 1'b0},
    '{32'd50, 1'b0, 32'd40, 1'b0, 17'd0, 1'b0},
    '{32'd20, 1'b0, 32'd30, 1'b0, 17'd0, 1'b0},
    '{32'd47, 1'b0, 32'd31, 1'b0, 17'd0, 1'b0},
    '{32'd48, 1'b0, 32'd31, 1'b0, 17'd0, 1'b0}
  };

  env_cfg_t phase_cfgs[] = '{
    '{16, 16, 32768, 16, 4096, 4096, 4096},
    '{100, 200, 20000, 300, 1, 65535, 2048},
    '{0, 50, 0, 50, 0, 0, 0},
    '{1000, 3000, 131071, 500, 65535, 1, 8192},
    '{64'hFFFFFFFF, 64'hFFFFFFFF, 65536, 64'hFFFFFFFF, 4096, 12288, 3000},
    '{37, 0, 40000, 1, 30000, 5000, 65535},
    '{5, 7, 1, 0, 500, 40000, 4096}
  };

  task automatic run_rows(input stim_row_t rows[]);
    foreach (rows[i]) begin
      if (rows[i].typed) level_q.push_back('{rows[i].lvl, rows[i].fin});
      else level_q.push_back(predict_level(rows[i].e, rows[i].k, rows[i].r));
      words_in++;
      in_valid_i <= 1'b1;
      elapsed_i <= rows[i].e;
      key_held_i <= rows[i].k;
      release_at_i <= rows[i].r;
      do @(posedge clk_i); while (!in_ready_o);
      @(negedge clk_i);
    end
  endtask

  initial begin
    env_cfg_t c;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset setting, then a small envelope
    run_rows(reset_rows);
    wait_idle();
    load_cfg(phase_cfgs[0]);
    run_rows(phase_rows);
    wait_idle();

    // Random phases under changing settings and idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 33; recv_idle_pct = 81;
      end else if (ph < 6) begin
        send_idle_pct = 81; recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (ph < phase_cfgs.size()) begin
        c = phase_cfgs[ph];
      end else begin
        c.a = $urandom_range(0, 4000); c.d = $urandom_range(0, 4000);
        c.s = $urandom_range(0, 131071); c.rl = $urandom_range(0, 4000);
        c.ac = $urandom_range(0, 65535); c.dc = $urandom_range(0, 65535);
        c.rc = $urandom_range(0, 65535);
      end
      load_cfg(c);
      repeat (WORDS_PER_PHASE) send_random();
      wait_idle();
    end

    $display("%0d words sent, %0d levels checked over %0d settings, %0d mismatches",
             words_in, words_out, NUM_PHASES + 2, mismatches);
    $display("covered attack, decay, sustain, release, finished, with sender and receiver stalls");
    if (mismatches == 0 && level_q.size() == 0) begin
      $display("adsr_envelope_level_tb: done, clean");
    end else begin
      $display("adsr_envelope_level_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/adsr_pkg.sv
sv/adsr_lg.sv
sv/adsr_div.sv
sv/adsr_pow.sv
sv/adsr_envelope_level.sv
dv/adsr_envelope_level_tb.sv
